// ===== hdl/lese_pkg.sv =====
`default_nettype none
package lese_pkg;

	localparam int DIM_DEFAULT = 3;
	localparam int LATENCY = 7;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MU = 2'd1;

	// Unique stress components, in output order.
	localparam int NCOMP = 6;
	localparam int K00 = 0;
	localparam int K01 = 1;
	localparam int K02 = 2;
	localparam int K11 = 3;
	localparam int K12 = 4;
	localparam int K22 = 5;
	localparam logic [NCOMP-1:0] DIAG_MASK = 6'b101001;
	localparam logic [NCOMP-1:0] THIRD_AXIS_MASK = 6'b110100;

	localparam int F_W = 32;
	localparam int MOD_W = 32;
	localparam int E_W = 34;
	localparam int TR_W = 35;
	localparam int P_W = E_W + MOD_W + 1;
	localparam int Q_W = TR_W + MOD_W + 1;
	localparam int SQ_W = 66;
	localparam int TSQ_W = 68;
	localparam int S_W = 70;
	localparam int DO_W = 68;
	localparam int ACC_W = 70;
	localparam int ACC_LO = 35;
	localparam int TSQ_LO = 34;
	localparam int PPA_W = ACC_W - ACC_LO + MOD_W;
	localparam int PPT_W = TSQ_W - TSQ_LO + MOD_W;
	localparam int A_W = 102;
	localparam int T_W = 100;
	localparam int EN_W = 105;
	localparam int EN_SHIFT = 27;
	localparam int OUT_W = 64;

	localparam logic signed [E_W-1:0] ONE_Q25 = 34'sd33554432;
	localparam logic [EN_W-1:0] HALF_EN = EN_W'(1) << (EN_SHIFT - 1);
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef logic signed [F_W-1:0] def_t;
	typedef logic signed [E_W-1:0] strain_t;
	typedef logic signed [TR_W-1:0] trace_t;
	typedef logic signed [P_W-1:0] shear_prod_t;
	typedef logic signed [Q_W-1:0] lam_prod_t;
	typedef logic [SQ_W-1:0] sq_t;
	typedef logic [TSQ_W-1:0] tsq_t;
	typedef logic signed [S_W-1:0] stress_pre_t;
	typedef logic signed [OUT_W-1:0] result_t;

	function automatic shear_prod_t mul_strain(strain_t e, logic [MOD_W-1:0] m);
		shear_prod_t ea;
		shear_prod_t ma;
		ea = {{(P_W-E_W){e[E_W-1]}}, e};
		ma = {{(P_W-MOD_W){1'b0}}, m};
		return ea * ma;
	endfunction

	function automatic lam_prod_t mul_trace(trace_t t, logic [MOD_W-1:0] m);
		lam_prod_t ta;
		lam_prod_t ma;
		ta = {{(Q_W-TR_W){t[TR_W-1]}}, t};
		ma = {{(Q_W-MOD_W){1'b0}}, m};
		return ta * ma;
	endfunction

	function automatic sq_t square_strain(strain_t e);
		logic signed [SQ_W+1:0] ea;
		logic signed [SQ_W+1:0] w;
		ea = {{(SQ_W+2-E_W){e[E_W-1]}}, e};
		w = ea * ea;
		return w[SQ_W-1:0];
	endfunction

	function automatic tsq_t square_trace(trace_t t);
		logic signed [TSQ_W:0] ta;
		logic signed [TSQ_W:0] w;
		ta = {{(TSQ_W+1-TR_W){t[TR_W-1]}}, t};
		w = ta * ta;
		return w[TSQ_W-1:0];
	endfunction

	// Drops one fractional bit, rounding half up, then clamps to 64 bits.
	function automatic result_t round_sat_stress(stress_pre_t s);
		stress_pre_t t;
		logic signed [S_W-2:0] r;
		t = s + S_W'(1);
		r = t[S_W-1:1];
		if (r[S_W-2:OUT_W-1] == {(S_W-OUT_W){r[OUT_W-1]}}) begin
			return r[OUT_W-1:0];
		end
		return r[S_W-2] ? OUT_MIN : OUT_MAX;
	endfunction

	// The sum already carries the rounding half; the energy is never negative.
	function automatic result_t sat_energy(logic [EN_W-1:0] en);
		logic [EN_W-EN_SHIFT-1:0] r;
		r = en[EN_W-1:EN_SHIFT];
		if (|r[EN_W-EN_SHIFT-1:OUT_W-1]) begin
			return OUT_MAX;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/linear_elastic_stress_energy.sv =====
`default_nettype none
// Small-strain isotropic linear elastic stress and energy density.
// A request is accepted at a rising edge with start high and busy low; busy
// stays low, so a new deformation gradient (def_00 .. def_22, signed Q8.24)
// can enter in every cycle. The result (six stress components and the energy
// density, signed with 40 fractional bits, saturated) appears on the result
// ports for one cycle with done high, after its request has passed every stage.
// Throughput is one item per cycle, set by the seven-stage pipeline: strain
// and trace, the strain-by-modulus products and squares, stress sums, stress
// rounding with the energy sum of squares, partial products of the energy,
// their sums, and the final energy rounding.
// The receiver cannot stall, so the pipeline never holds.
// lame_lambda (index 0) and shear_mu (index 1), unsigned Q16.16, are written
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high and other
// indexes are ignored. Write them only while no request is in flight.
// Reset clears both moduli to zero and empties the pipeline.
// With DIM set to two, the third row and column of the input are ignored and
// stress_02, stress_12 and stress_22 are zero.
module linear_elastic_stress_energy
	import lese_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MOD_W-1:0]     cfg_data,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [31:0]   def_00,
	input  wire logic signed [31:0]   def_01,
	input  wire logic signed [31:0]   def_02,
	input  wire logic signed [31:0]   def_10,
	input  wire logic signed [31:0]   def_11,
	input  wire logic signed [31:0]   def_12,
	input  wire logic signed [31:0]   def_20,
	input  wire logic signed [31:0]   def_21,
	input  wire logic signed [31:0]   def_22,
	output logic                      done,
	output logic signed [63:0]        stress_00,
	output logic signed [63:0]        stress_01,
	output logic signed [63:0]        stress_02,
	output logic signed [63:0]        stress_11,
	output logic signed [63:0]        stress_12,
	output logic signed [63:0]        stress_22,
	output logic signed [63:0]        energy_density
);

	localparam bit THREE_D = (DIM == 3);

	logic [MOD_W-1:0] lambda_q;
	logic [MOD_W-1:0] mu_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	strain_t e_d [NCOMP];
	trace_t tr_d;
	stress_pre_t spre_d [NCOMP];

	strain_t e_s1 [NCOMP];
	trace_t tr_s1;
	shear_prod_t p_s2 [NCOMP];
	lam_prod_t q_s2;
	sq_t sq_s2 [NCOMP];
	tsq_t tsq_s2;
	stress_pre_t spre_s3 [NCOMP];
	logic [DO_W-1:0] diag_s3;
	logic [DO_W-1:0] off_s3;
	tsq_t tsq_s3;
	result_t stress_s4 [NCOMP];
	logic [ACC_W-1:0] acc_s4;
	tsq_t tsq_s4;
	result_t stress_s5 [NCOMP];
	logic [PPA_W-1:0] ppa_lo_s5;
	logic [PPA_W-1:0] ppa_hi_s5;
	logic [PPT_W-1:0] ppt_lo_s5;
	logic [PPT_W-1:0] ppt_hi_s5;
	result_t stress_s6 [NCOMP];
	logic [A_W-1:0] asum_s6;
	logic [T_W-1:0] tsum_s6;
	logic [EN_W-1:0] en_d;
	result_t stress_s7 [NCOMP];
	result_t energy_s7;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
			mu_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LAME_LAMBDA: lambda_q <= cfg_data;
				REG_SHEAR_MU:    mu_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Strain in units of 2^-25: e_ij = F_ij + F_ji, less one on the diagonal.
	// Zeroing the third row and column in two dimensions also drops them
	// from the energy sum.
	always_comb begin
		e_d[K00] = {def_00[31], def_00, 1'b0} - ONE_Q25;
		e_d[K11] = {def_11[31], def_11, 1'b0} - ONE_Q25;
		e_d[K01] = {{2{def_01[31]}}, def_01} + {{2{def_10[31]}}, def_10};
		if (THREE_D) begin
			e_d[K22] = {def_22[31], def_22, 1'b0} - ONE_Q25;
			e_d[K02] = {{2{def_02[31]}}, def_02} + {{2{def_20[31]}}, def_20};
			e_d[K12] = {{2{def_12[31]}}, def_12} + {{2{def_21[31]}}, def_21};
		end else begin
			e_d[K22] = '0;
			e_d[K02] = '0;
			e_d[K12] = '0;
		end
		tr_d = {e_d[K00][E_W-1], e_d[K00]} + {e_d[K11][E_W-1], e_d[K11]}
			+ {e_d[K22][E_W-1], e_d[K22]};
	end

	always_comb begin
		for (int k = 0; k < NCOMP; k++) begin
			spre_d[k] = {{(S_W-P_W){p_s2[k][P_W-1]}}, p_s2[k]} <<< 1;
			if (DIAG_MASK[k]) begin
				spre_d[k] = spre_d[k] + {{(S_W-Q_W){q_s2[Q_W-1]}}, q_s2};
			end
		end
	end

	// Energy before rounding: 2*mu*(e:e) + lambda*tr^2, plus the rounding half.
	assign en_d = (EN_W'(asum_s6) << 1) + EN_W'(tsum_s6) + HALF_EN;

	always_ff @(posedge clk) begin
		// Stage 1: strain and trace.
		for (int k = 0; k < NCOMP; k++) begin
			e_s1[k] <= e_d[k];
		end
		tr_s1 <= tr_d;

		// Stage 2: products with the moduli and squares.
		for (int k = 0; k < NCOMP; k++) begin
			p_s2[k] <= mul_strain(e_s1[k], mu_q);
			sq_s2[k] <= square_strain(e_s1[k]);
		end
		q_s2 <= mul_trace(tr_s1, lambda_q);
		tsq_s2 <= square_trace(tr_s1);

		// Stage 3: stress before rounding; diagonal and off-diagonal squares.
		for (int k = 0; k < NCOMP; k++) begin
			spre_s3[k] <= spre_d[k];
		end
		diag_s3 <= DO_W'(sq_s2[K00]) + DO_W'(sq_s2[K11]) + DO_W'(sq_s2[K22]);
		off_s3 <= DO_W'(sq_s2[K01]) + DO_W'(sq_s2[K02]) + DO_W'(sq_s2[K12]);
		tsq_s3 <= tsq_s2;

		// Stage 4: rounded stress; off-diagonal terms appear twice in e:e.
		for (int k = 0; k < NCOMP; k++) begin
			if (!THREE_D && THIRD_AXIS_MASK[k]) begin
				stress_s4[k] <= '0;
			end else begin
				stress_s4[k] <= round_sat_stress(spre_s3[k]);
			end
		end
		acc_s4 <= ACC_W'(diag_s3) + (ACC_W'(off_s3) << 1);
		tsq_s4 <= tsq_s3;

		// Stage 5: the wide energy products as narrower partial products.
		stress_s5 <= stress_s4;
		ppa_lo_s5 <= PPA_W'(acc_s4[ACC_LO-1:0]) * PPA_W'(mu_q);
		ppa_hi_s5 <= PPA_W'(acc_s4[ACC_W-1:ACC_LO]) * PPA_W'(mu_q);
		ppt_lo_s5 <= PPT_W'(tsq_s4[TSQ_LO-1:0]) * PPT_W'(lambda_q);
		ppt_hi_s5 <= PPT_W'(tsq_s4[TSQ_W-1:TSQ_LO]) * PPT_W'(lambda_q);

		// Stage 6: recombine the partial products.
		stress_s6 <= stress_s5;
		asum_s6 <= A_W'({ppa_hi_s5, {ACC_LO{1'b0}}}) + A_W'(ppa_lo_s5);
		tsum_s6 <= T_W'({ppt_hi_s5, {TSQ_LO{1'b0}}}) + T_W'(ppt_lo_s5);

		// Stage 7: rounded and clamped energy.
		stress_s7 <= stress_s6;
		energy_s7 <= sat_energy(en_d);
	end

	assign done = valid_s7;
	assign stress_00 = stress_s7[K00];
	assign stress_01 = stress_s7[K01];
	assign stress_02 = stress_s7[K02];
	assign stress_11 = stress_s7[K11];
	assign stress_12 = stress_s7[K12];
	assign stress_22 = stress_s7[K22];
	assign energy_density = energy_s7;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result did not follow its request at the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	a_energy_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !energy_density[OUT_W-1])
		else $error("energy density came out negative");

	a_two_d_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !THREE_D |-> stress_02 == '0 && stress_12 == '0 && stress_22 == '0)
		else $error("third-axis stress is not zero in two dimensions");

endmodule
`default_nettype wire
